/* design/csli_pkg.sv */
package csli_pkg;

	localparam int NCOL   = 6;
	localparam int MASK_W = 6;
	localparam int COL_W  = 3;
	localparam int Q_W    = 32;
	localparam int NUM_W  = 52;
	localparam int DEN_W  = 22;
	localparam int CMP_W  = DEN_W + Q_W;
	localparam int DIV_ST = 16;
	localparam int BITS_PER_ST = Q_W / DIV_ST;

	localparam logic signed [32:0] ONE_Q28 = 33'sd268435456;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam logic [31:0]        MAG_LIM = 32'h80000000;
	localparam logic [MASK_W-1:0]  MASK_RESET = 6'h3f;

	typedef struct packed {
		logic signed [15:0] grad_x;
		logic signed [15:0] grad_y;
		logic signed [15:0] grad_z;
		logic signed [15:0] sphere_x;
		logic signed [15:0] sphere_y;
		logic signed [15:0] sphere_z;
		logic [15:0]        depth;
		logic               skip_pixel;
		logic               frame_end;
	} in_t;

	typedef struct packed {
		logic signed [31:0] entry_value;
		logic [COL_W-1:0]   column;
		logic               row_last;
		logic               frame_last;
	} out_t;

	typedef struct packed {
		logic                  valid;
		logic [2:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]      den;
		logic [2:0]            neg;
		logic [2:0]            ovf;
		logic [2:0][31:0]      rot;
		logic                  skip;
		logic                  fend;
	} front_t;

	typedef struct packed {
		logic                 valid;
		logic [NCOL-1:0][31:0] vals;
		logic                 fend;
	} row_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'(SAT_MAX))
			r = SAT_MAX;
		else if (v < 33'(SAT_MIN))
			r = SAT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* design/cartesian_sphere_luminance_interaction_core.sv */
// channel  | valid      | stall      | payload
// input    | in_valid   | in_stall   | in_data  (csli_pkg::in_t, one pixel)
// output   | out_valid  | out_stall  | out_data (csli_pkg::out_t, one entry)
// config   | cfg_we     | -          | cfg_data (dof_mask)
//
// the pipeline has four arithmetic stages, sixteen divider stages at two
// quotient bits each, and the output row register
// one entry leaves per cycle while out_stall is low, one for each bit set
// in the mask; a new pixel enters every cycle, unless stalled, only when
// the mask has at most one bit set, otherwise once per row drained
// reset clears all valid bits and sets the mask to all six columns
// while a valid row waits and the held row is not leaving on its final entry, the whole pipeline holds
module cartesian_sphere_luminance_interaction_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  csli_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output csli_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [csli_pkg::MASK_W-1:0]   cfg_data
);

	logic [csli_pkg::MASK_W-1:0] dof_mask_q;
	logic                        en;
	csli_pkg::front_t            front;
	csli_pkg::row_t              row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dof_mask_q <= csli_pkg::MASK_RESET;
		else if (cfg_we)
			dof_mask_q <= cfg_data;
	end

	assign in_stall = !en;

	csli_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.front    (front)
	);

	csli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.front  (front),
		.row    (row)
	);

	csli_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (row),
		.dof_mask  (dof_mask_q),
		.en        (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* design/csli_front.sv */
module csli_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  csli_pkg::in_t     in_data,
	output csli_pkg::front_t  front
);

	localparam int NUM_W_L = csli_pkg::NUM_W;

	logic signed [15:0] gin [3];
	logic signed [15:0] sin [3];

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [15:0] g_s1 [3];
	logic signed [31:0] ss_s1 [3][3];
	logic signed [31:0] gs_s1 [3][3];
	logic [15:0]        d_s1, d_s2, d_s3;
	logic               skip_s1, skip_s2, skip_s3, skip_s4;
	logic               fend_s1, fend_s2, fend_s3, fend_s4;

	logic signed [32:0] t_c [3][3];
	logic signed [32:0] rd_c [3];
	logic signed [48:0] p_s2 [3][3];
	logic [2:0][31:0]   rot_s2, rot_s3, rot_s4;

	logic signed [NUM_W_L-1:0] n_s3 [3];

	logic [NUM_W_L-1:0]          mag_c [3];
	logic [NUM_W_L-1:0]          num_c [3];
	logic [csli_pkg::DEN_W-1:0]  den_c;
	logic [2:0][NUM_W_L-1:0]     num_s4;
	logic [csli_pkg::DEN_W-1:0]  den_s4;
	logic [2:0]                  neg_s4, ovf_s4;

	assign gin = '{in_data.grad_x, in_data.grad_y, in_data.grad_z};
	assign sin = '{in_data.sphere_x, in_data.sphere_y, in_data.sphere_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: all sphere and gradient-by-sphere products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				g_s1[i] <= gin[i];
				for (int j = 0; j < 3; j++) begin
					ss_s1[i][j] <= sin[i] * sin[j];
					gs_s1[i][j] <= gin[i] * sin[j];
				end
			end
			d_s1    <= in_data.depth;
			skip_s1 <= in_data.skip_pixel;
			fend_s1 <= in_data.frame_end;
		end
	end

	// stage 2: gradient times (s_j s_i - e_ij), and the cross product
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				t_c[i][j] = 33'(ss_s1[i][j]);
				if (i == j)
					t_c[i][j] = t_c[i][j] - csli_pkg::ONE_Q28;
			end
		end
		rd_c[0] = 33'(gs_s1[2][1]) - 33'(gs_s1[1][2]);
		rd_c[1] = 33'(gs_s1[0][2]) - 33'(gs_s1[2][0]);
		rd_c[2] = 33'(gs_s1[1][0]) - 33'(gs_s1[0][1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					p_s2[i][j] <= g_s1[j] * t_c[i][j];
				rot_s2[i] <= csli_pkg::sat32(rd_c[i]);
			end
			d_s2    <= d_s1;
			skip_s2 <= skip_s1;
			fend_s2 <= fend_s1;
		end
	end

	// stage 3: negated sum per translation column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				n_s3[i] <= NUM_W_L'(0) - NUM_W_L'(p_s2[i][0]) - NUM_W_L'(p_s2[i][1])
					- NUM_W_L'(p_s2[i][2]);
			rot_s3  <= rot_s2;
			d_s3    <= d_s2;
			skip_s3 <= skip_s2;
			fend_s3 <= fend_s2;
		end
	end

	// stage 4: magnitude with half-divisor rounding term, overflow check
	always_comb begin
		den_c = {d_s3, 6'b0};
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = n_s3[i][NUM_W_L-1] ? NUM_W_L'(-n_s3[i]) : NUM_W_L'(n_s3[i]);
			num_c[i] = mag_c[i] + NUM_W_L'({d_s3, 5'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= num_c[i];
				neg_s4[i] <= n_s3[i][NUM_W_L-1];
				ovf_s4[i] <= csli_pkg::CMP_W'(num_c[i]) >= {den_c, 32'b0};
			end
			den_s4  <= den_c;
			rot_s4  <= rot_s3;
			skip_s4 <= skip_s3;
			fend_s4 <= fend_s3;
		end
	end

	always_comb begin
		front.valid = v_s4;
		front.num   = num_s4;
		front.den   = den_s4;
		front.neg   = neg_s4;
		front.ovf   = ovf_s4;
		front.rot   = rot_s4;
		front.skip  = skip_s4;
		front.fend  = fend_s4;
	end

endmodule

/* design/csli_div.sv */
module csli_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  csli_pkg::front_t  front,
	output csli_pkg::row_t    row
);

	localparam int ST    = csli_pkg::DIV_ST;
	localparam int NW    = csli_pkg::NUM_W;
	localparam int CW    = csli_pkg::CMP_W;
	localparam int DW    = csli_pkg::DEN_W;
	localparam int LAST  = ST - 1;

	logic              v_s    [ST];
	logic [NW-1:0]     rem_s  [ST][3];
	logic [31:0]       quo_s  [ST][3];
	logic [DW-1:0]     den_s  [ST];
	logic [2:0]        neg_s  [ST];
	logic [2:0]        ovf_s  [ST];
	logic [2:0][31:0]  rot_s  [ST];
	logic              skip_s [ST];
	logic              fend_s [ST];

	logic [NW-1:0]     rem_c  [ST][3];
	logic [31:0]       quo_c  [ST][3];

	logic [31:0]        mag_c [3];
	logic signed [31:0] val_c [3];

	// restoring division, two quotient bits per stage, high bits first
	always_comb begin
		logic [NW-1:0] r;
		logic [31:0]   qv;
		logic [DW-1:0] dd;
		logic [CW-1:0] dsh;
		int            sh;
		for (int k = 0; k < ST; k++) begin
			dd = (k == 0) ? front.den : den_s[(k == 0) ? 0 : k - 1];
			for (int l = 0; l < 3; l++) begin
				r  = (k == 0) ? front.num[l] : rem_s[(k == 0) ? 0 : k - 1][l];
				qv = (k == 0) ? 32'd0 : quo_s[(k == 0) ? 0 : k - 1][l];
				for (int b = 0; b < csli_pkg::BITS_PER_ST; b++) begin
					sh  = csli_pkg::Q_W - 1 - csli_pkg::BITS_PER_ST * k - b;
					dsh = CW'(dd) << sh;
					if (CW'(r) >= dsh) begin
						r      = r - dsh[NW-1:0];
						qv[sh] = 1'b1;
					end
				end
				rem_c[k][l] = r;
				quo_c[k][l] = qv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ST; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= front.valid;
			for (int k = 1; k < ST; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ST; k++) begin
				rem_s[k] <= rem_c[k];
				quo_s[k] <= quo_c[k];
			end
			den_s[0]  <= front.den;
			neg_s[0]  <= front.neg;
			ovf_s[0]  <= front.ovf;
			rot_s[0]  <= front.rot;
			skip_s[0] <= front.skip;
			fend_s[0] <= front.fend;
			for (int k = 1; k < ST; k++) begin
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				rot_s[k]  <= rot_s[k-1];
				skip_s[k] <= skip_s[k-1];
				fend_s[k] <= fend_s[k-1];
			end
		end
	end

	// clamp quotient to 2^31, apply sign, saturate the positive side
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (ovf_s[LAST][l] || quo_s[LAST][l] > csli_pkg::MAG_LIM)
				mag_c[l] = csli_pkg::MAG_LIM;
			else
				mag_c[l] = quo_s[LAST][l];
			if (neg_s[LAST][l])
				val_c[l] = -$signed(mag_c[l]);
			else if (mag_c[l][31])
				val_c[l] = csli_pkg::SAT_MAX;
			else
				val_c[l] = $signed(mag_c[l]);
		end
	end

	always_comb begin
		row.valid = v_s[LAST];
		row.fend  = fend_s[LAST];
		for (int l = 0; l < 3; l++) begin
			row.vals[l]     = skip_s[LAST] ? 32'd0 : val_c[l];
			row.vals[l + 3] = skip_s[LAST] ? 32'd0 : rot_s[LAST][l];
		end
	end

endmodule

/* design/csli_serial.sv */
module csli_serial (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csli_pkg::row_t                row,
	input  logic [csli_pkg::MASK_W-1:0]   dof_mask,
	output logic                          en,
	output logic                          out_valid,
	input  logic                          out_stall,
	output csli_pkg::out_t                out_data
);

	logic [csli_pkg::MASK_W-1:0]       rem_q;
	logic [csli_pkg::NCOL-1:0][31:0]   vals_q;
	logic                              fend_q;

	logic [csli_pkg::COL_W-1:0] col;
	logic                       single;
	logic                       take;
	logic                       load_ok;
	logic                       load;

	always_comb begin
		col = '0;
		for (int k = csli_pkg::NCOL - 1; k >= 0; k--)
			if (rem_q[k])
				col = csli_pkg::COL_W'(k);
	end

	assign single    = (rem_q & (rem_q - 1'b1)) == '0;
	assign out_valid = |rem_q;
	assign take      = out_valid && !out_stall;
	// a new row may enter when no row is held or the held row's final entry is taken
	assign load_ok   = !out_valid || (take && single);
	assign en        = !row.valid || load_ok;
	assign load      = row.valid && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rem_q <= '0;
		else if (load)
			rem_q <= dof_mask;
		else if (take)
			rem_q <= rem_q & (rem_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vals_q <= row.vals;
			fend_q <= row.fend;
		end
	end

	always_comb begin
		out_data.entry_value = vals_q[col];
		out_data.column      = col;
		out_data.row_last    = single;
		out_data.frame_last  = single && fend_q;
	end

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> rem_q != '0)
		else $error("pipeline held with no row draining");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |-> out_data.row_last)
		else $error("frame_last without row_last");

	a_row_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.row_last |=> out_valid)
		else $error("row ended before its last entry");

	a_col_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_q[col] && col < csli_pkg::COL_W'(csli_pkg::NCOL))
		else $error("entry column not pending");

endmodule

/* tb/tb_cartesian_sphere_luminance_interaction_core.sv */
module tb_cartesian_sphere_luminance_interaction_core;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int LONG_HOLD      = 400;

	class entry_scoreboard;
		csli_pkg::out_t pending[$];
		int   errors;
		int   rows;
		int   entries;

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		// translation column: negated gradient dot (s*s_i - e_i), over depth
		function longint trans_col(longint g[3], longint s[3], int i, longint d);
			longint n, t;
			longint unsigned mag, quo;
			n = 0;
			for (int j = 0; j < 3; j++) begin
				t = s[j] * s[i];
				if (j == i)
					t -= 64'sd268435456;
				n -= g[j] * t;
			end
			if (d == 0)
				return (n < 0) ? -64'sd2147483648 : 64'sd2147483647;
			mag = (n < 0) ? -n : n;
			quo = (mag + d * 32) / (d * 64);
			if (quo > 64'h80000000)
				quo = 64'h80000000;
			return clamp32((n < 0) ? -longint'(quo) : longint'(quo));
		endfunction

		function void note_pixel(csli_pkg::in_t px, logic [csli_pkg::MASK_W-1:0] mask);
			longint g[3], s[3], v[csli_pkg::NCOL];
			longint d;
			int last;
			csli_pkg::out_t e;
			g[0] = px.grad_x;   g[1] = px.grad_y;   g[2] = px.grad_z;
			s[0] = px.sphere_x; s[1] = px.sphere_y; s[2] = px.sphere_z;
			d = longint'({1'b0, px.depth});
			for (int k = 0; k < csli_pkg::NCOL; k++)
				v[k] = 0;
			if (!px.skip_pixel) begin
				for (int k = 0; k < 3; k++)
					v[k] = trans_col(g, s, k, d);
				v[3] = clamp32(g[2] * s[1] - g[1] * s[2]);
				v[4] = clamp32(g[0] * s[2] - g[2] * s[0]);
				v[5] = clamp32(g[1] * s[0] - g[0] * s[1]);
			end
			last = -1;
			for (int k = 0; k < csli_pkg::NCOL; k++)
				if (mask[k])
					last = k;
			rows++;
			for (int k = 0; k < csli_pkg::NCOL; k++) begin
				if (!mask[k])
					continue;
				e.entry_value = v[k][31:0];
				e.column      = k[csli_pkg::COL_W-1:0];
				e.row_last    = (k == last);
				e.frame_last  = (k == last) && px.frame_end;
				pending.push_back(e);
			end
		endfunction

		function void check_entry(csli_pkg::out_t got);
			csli_pkg::out_t exp_e;
			entries++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected entry %h", $time, got);
				return;
			end
			exp_e = pending.pop_front();
			if (got.entry_value !== exp_e.entry_value) begin
				errors++;
				$display("%0t: entry_value expected %0d actual %0d", $time,
					exp_e.entry_value, got.entry_value);
			end
			if (got.column !== exp_e.column) begin
				errors++;
				$display("%0t: column expected %0d actual %0d", $time,
					exp_e.column, got.column);
			end
			if (got.row_last !== exp_e.row_last) begin
				errors++;
				$display("%0t: row_last expected %0b actual %0b", $time,
					exp_e.row_last, got.row_last);
			end
			if (got.frame_last !== exp_e.frame_last) begin
				errors++;
				$display("%0t: frame_last expected %0b actual %0b", $time,
					exp_e.frame_last, got.frame_last);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	csli_pkg::in_t               in_data = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	csli_pkg::out_t              out_data;
	logic                        cfg_we = 1'b0;
	logic [csli_pkg::MASK_W-1:0] cfg_data = '0;

	entry_scoreboard             sb = new();
	logic [csli_pkg::MASK_W-1:0] mask_now = csli_pkg::MASK_RESET;
	bit                          send_busy = 1'b0;
	bit                          recv_busy = 1'b0;
	bit                          hold_request = 1'b0;
	int                          idle_cycles = 0;
	int                          masks_used = 1;

	cartesian_sphere_luminance_interaction_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_entry(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d entries outstanding", $time,
				sb.pending.size());
			$display("cartesian_sphere_luminance_interaction_core test failed");
			$finish;
		end
	end

	// receiver: random per-entry stall, with quiet stretches and one long hold
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				n = LONG_HOLD;
			end else
				n = recv_busy ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
				@(negedge clk) out_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
		end
	end

	// valid stays high across back-to-back transactions
	task automatic send_pixel(csli_pkg::in_t px);
		int gap;
		gap = send_busy ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= px;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.note_pixel(px, mask_now);
	endtask

	task automatic drain_and_config(logic [csli_pkg::MASK_W-1:0] m);
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(negedge clk) cfg_we <= 1'b0;
		mask_now = m;
		masks_used++;
	endtask

	function automatic csli_pkg::in_t make_pixel(bit wild_sphere);
		csli_pkg::in_t px;
		int r;
		px.grad_x = 16'($urandom);
		px.grad_y = 16'($urandom);
		px.grad_z = 16'($urandom);
		if (wild_sphere) begin
			px.sphere_x = 16'($urandom);
			px.sphere_y = 16'($urandom);
			px.sphere_z = 16'($urandom);
		end else begin
			px.sphere_x = 16'($urandom_range(0, 32768) - 16384);
			px.sphere_y = 16'($urandom_range(0, 32768) - 16384);
			px.sphere_z = 16'($urandom_range(0, 32768) - 16384);
		end
		r = $urandom_range(0, 19);
		if (r == 0)
			px.depth = '0;
		else if (r < 5)
			px.depth = 16'($urandom_range(1, 255));
		else
			px.depth = 16'($urandom);
		px.skip_pixel = ($urandom_range(0, 9) == 0);
		px.frame_end  = ($urandom_range(0, 7) == 0);
		return px;
	endfunction

	function automatic csli_pkg::in_t fixed_pixel(int gx, int gy, int gz, int sx, int sy,
			int sz, int d, bit skip, bit fend);
		csli_pkg::in_t px;
		px.grad_x = 16'(gx);   px.grad_y = 16'(gy);   px.grad_z = 16'(gz);
		px.sphere_x = 16'(sx); px.sphere_y = 16'(sy); px.sphere_z = 16'(sz);
		px.depth = 16'(d);
		px.skip_pixel = skip;
		px.frame_end = fend;
		return px;
	endfunction

	initial begin
		logic [csli_pkg::MASK_W-1:0] masks[8];
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed pixels under the reset mask
		send_pixel(fixed_pixel(0, 0, 0, 0, 0, 0, 256, 0, 0));
		send_pixel(fixed_pixel(32767, 32767, 32767, 16384, 16384, 16384, 1, 0, 0));
		send_pixel(fixed_pixel(-32768, -32768, -32768, -16384, -16384, -16384, 1, 0, 1));
		send_pixel(fixed_pixel(32767, -32768, 32767, 16384, 0, 0, 65535, 0, 0));
		send_pixel(fixed_pixel(-32768, 32767, -32768, 0, -16384, 0, 0, 0, 0));
		send_pixel(fixed_pixel(100, -200, 300, 0, 0, 16384, 0, 0, 1));
		send_pixel(fixed_pixel(-100, 200, -300, 0, 0, 16384, 0, 0, 0));
		send_pixel(fixed_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(fixed_pixel(12345, -23456, 54, 9000, -8000, 11000, 0, 1, 1));
		send_pixel(fixed_pixel(32767, 32767, 32767, 16384, 16384, 16384, 0, 1, 0));
		send_pixel(fixed_pixel(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0));
		send_pixel(fixed_pixel(32767, -32768, 32767, 32767, -32768, 32767, 1, 0, 1));
		send_pixel(fixed_pixel(-32768, 32767, 32767, 32767, 32767, -32768, 65535, 0, 0));
		send_pixel(fixed_pixel(1, 1, 1, 11585, 11585, 0, 3, 0, 0));
		send_pixel(fixed_pixel(-1, -1, -1, -11585, 0, 11585, 2, 0, 1));
		send_pixel(fixed_pixel(7, -7, 7, 16384, 0, 0, 128, 0, 0));

		masks[0] = 6'h01; masks[1] = 6'h20; masks[2] = 6'h3f; masks[3] = 6'h15;
		masks[4] = 6'h2a; masks[5] = 6'h07; masks[6] = 6'h38; masks[7] = 6'h00;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				masks[ph] = 6'($urandom_range(1, 63));
			drain_and_config(masks[ph]);
			if (ph == 2)
				hold_request = 1'b1;
			for (int i = 0; i < 60; i++) begin
				if (i % 20 == 0) begin
					send_busy = (ph == 2 && i == 0) || ($urandom_range(0, 3) == 0);
					recv_busy = ($urandom_range(0, 3) == 0);
				end
				send_pixel(make_pixel($urandom_range(0, 4) == 0));
			end
			send_busy = 1'b0;
		end

		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixels, %0d entries checked, %0d column masks", sb.rows,
			sb.entries, masks_used);
		$display("including zero depth, skipped pixels, frame ends and saturating values");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("cartesian_sphere_luminance_interaction_core test passed");
		else
			$display("cartesian_sphere_luminance_interaction_core test failed");
		$finish;
	end

endmodule
